>>> design/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, constants and saturation helper of the look-at matrix block.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int FRAC_BITS_DEF = 16;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_in;

    typedef struct packed {
        logic        [1:0]  row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
        logic               degenerate;
    } t_out;

    // Job handed from the front to the back: position, up, pos - target.
    typedef struct packed {
        logic signed [2:0][31:0] pos;
        logic signed [2:0][31:0] up;
        logic signed [2:0][31:0] dir;
    } t_job;

    localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
    localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> design/lav_front.sv
// ----------------------------------------------------------------------------
// lav_front
// Accept requests, form pos - target with saturation, hold jobs in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lav_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  lav_pkg::t_in  i_item,
    output logic          o_job_valid,
    input  logic          i_job_take,
    output lav_pkg::t_job o_job
);
    import lav_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;
    logic       w_acc;

    always_comb begin
        w_job.pos[0] = i_item.pos_x;
        w_job.pos[1] = i_item.pos_y;
        w_job.pos[2] = i_item.pos_z;
        w_job.up[0]  = i_item.up_x;
        w_job.up[1]  = i_item.up_y;
        w_job.up[2]  = i_item.up_z;
        w_job.dir[0] = sat32(68'(i_item.pos_x) - 68'(i_item.target_x));
        w_job.dir[1] = sat32(68'(i_item.pos_y) - 68'(i_item.target_y));
        w_job.dir[2] = sat32(68'(i_item.pos_z) - 68'(i_item.target_z));
    end

    assign full        = (r_cnt == 2'd2);
    assign w_acc       = push && !full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wp <= ~r_wp;
            end
            if (i_job_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_acc) - 2'(i_job_take);
        end
    end

endmodule

>>> design/lav_back.sv
// ----------------------------------------------------------------------------
// lav_back
// Sequencer with one shared multiplier, a two-digit-per-cycle square root
// and three restoring divider lanes; emits the four matrix rows.
// ----------------------------------------------------------------------------
module lav_back #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_take,
    input  lav_pkg::t_job i_job,
    output logic          o_row_push,
    input  logic          i_row_full,
    output lav_pkg::t_out o_row
);
    import lav_pkg::*;

    localparam int NW = 33 + FRAC_BITS;
    localparam logic [4:0] DIV_LAST = 5'(FRAC_BITS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_SQRT  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_CROSS = 7'b0010000,
        S_DOT   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state                  r_state;
    logic                    r_pass, r_degen;
    logic signed [2:0][31:0] r_pos, r_up, r_vec, r_fw, r_sn, r_uw, r_tr;
    logic [4:0]              r_cnt;
    logic                    r_pv;
    logic [3:0]              r_ptag;
    logic signed [63:0]      r_prod;
    logic signed [65:0]      r_acc;
    logic [63:0]             r_s;
    logic [34:0]             r_srem;
    logic [31:0]             r_root;
    logic [31:0]             r_len;
    logic [31:0]             r_rem  [3];
    logic [FRAC_BITS:0]      r_dnum [3];
    logic [FRAC_BITS:0]      r_quo  [3];
    logic [1:0]              r_row;

    // multiplier operand select
    logic signed [31:0] m_a, m_b;
    logic               m_go;
    logic [1:0]         m_ia, m_ib, m_row;
    logic [1:0]         h_row, h_k;

    always_comb begin
        m_ia = 2'd0; m_ib = 2'd0; m_row = 2'd0;
        m_a = r_vec[0]; m_b = r_vec[0]; m_go = 1'b0;
        case (r_state)
            S_SQ: begin
                m_go = (r_cnt < 5'd3);
                m_ia = r_cnt[1:0];
                m_a  = r_vec[m_ia];
                m_b  = r_vec[m_ia];
            end
            S_CROSS: begin
                m_go = (r_cnt < 5'd6);
                case (r_cnt[2:0])
                    3'd0:    begin m_ia = 2'd1; m_ib = 2'd2; end
                    3'd1:    begin m_ia = 2'd2; m_ib = 2'd1; end
                    3'd2:    begin m_ia = 2'd2; m_ib = 2'd0; end
                    3'd3:    begin m_ia = 2'd0; m_ib = 2'd2; end
                    3'd4:    begin m_ia = 2'd0; m_ib = 2'd1; end
                    default: begin m_ia = 2'd1; m_ib = 2'd0; end
                endcase
                m_a = r_pass ? r_fw[m_ia] : r_up[m_ia];
                m_b = r_pass ? r_sn[m_ib] : r_fw[m_ib];
            end
            S_DOT: begin
                m_go = (r_cnt < 5'd9);
                case (r_cnt[3:0])
                    4'd0, 4'd1, 4'd2: m_row = 2'd0;
                    4'd3, 4'd4, 4'd5: m_row = 2'd1;
                    default:          m_row = 2'd2;
                endcase
                m_ia = 2'(r_cnt[3:0] - {m_row, 1'b0} - {2'b00, m_row});
                case (m_row)
                    2'd0:    m_a = r_sn[m_ia];
                    2'd1:    m_a = r_uw[m_ia];
                    default: m_a = r_fw[m_ia];
                endcase
                m_b = r_pos[m_ia];
            end
            default: ;
        endcase
    end

    // row and component of the product being accumulated in the dot phase
    always_comb begin
        case (r_ptag)
            4'd0, 4'd1, 4'd2: h_row = 2'd0;
            4'd3, 4'd4, 4'd5: h_row = 2'd1;
            default:          h_row = 2'd2;
        endcase
        h_k = 2'(r_ptag - {h_row, 1'b0} - {2'b00, h_row});
    end

    // accumulation paths
    logic [63:0]        a_sum;
    logic signed [65:0] a_cdiff, a_dsum;
    logic signed [31:0] a_cross, a_tr;
    always_comb begin
        a_sum   = ((r_ptag == 4'd0) ? 64'd0 : r_s) + $unsigned(r_prod);
        a_cdiff = r_acc - 66'(r_prod);
        a_cross = sat32(68'(a_cdiff >>> FRAC_BITS));
        a_dsum  = ((h_k == 2'd0) ? 66'sd0 : r_acc) + 66'(r_prod);
        a_tr    = sat32(-(68'(a_dsum >>> FRAC_BITS)));
    end

    // square root, two digits per cycle
    logic [34:0] q_rem  [3];
    logic [31:0] q_root [3];
    logic [63:0] q_s    [3];
    logic [34:0] q_t, q_trial;
    always_comb begin
        q_rem[0] = r_srem; q_root[0] = r_root; q_s[0] = r_s;
        for (int j = 0; j < 2; j++) begin
            q_t     = {q_rem[j][32:0], q_s[j][63:62]};
            q_trial = {1'b0, q_root[j], 2'b01};
            q_s[j+1] = {q_s[j][61:0], 2'b00};
            if (q_t >= q_trial) begin
                q_rem[j+1]  = q_t - q_trial;
                q_root[j+1] = {q_root[j][30:0], 1'b1};
            end else begin
                q_rem[j+1]  = q_t;
                q_root[j+1] = {q_root[j][30:0], 1'b0};
            end
        end
    end

    // divider setup and lanes
    logic [31:0]           v_mag  [3];
    logic [NW-1:0]         v_num  [3];
    logic [32:0]           d_t    [3];
    logic                  d_ge   [3];
    logic [32:0]           d_rem  [3];
    logic [FRAC_BITS:0]    d_quo  [3];
    logic signed [31:0]    d_res  [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_mag[i] = r_vec[i][31] ? 32'(-33'(r_vec[i])) : r_vec[i];
            v_num[i] = {1'b0, v_mag[i], {FRAC_BITS{1'b0}}}
                       + NW'(q_root[2][31:1]);
            d_t[i]   = {r_rem[i], r_dnum[i][FRAC_BITS]};
            d_ge[i]  = d_t[i] >= {1'b0, r_len};
            d_rem[i] = d_ge[i] ? d_t[i] - {1'b0, r_len} : d_t[i];
            d_quo[i] = {r_quo[i][FRAC_BITS-1:0], d_ge[i]};
            d_res[i] = r_vec[i][31] ? -(32'(d_quo[i])) : 32'(d_quo[i]);
        end
    end

    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign o_row_push = (r_state == S_EMIT) && !i_row_full;

    always_comb begin
        o_row.row_index  = r_row;
        o_row.last_row   = (r_row == 2'd3);
        o_row.degenerate = r_degen;
        o_row.col3       = r_tr[r_row[1] ? 2'd2 : {1'b0, r_row[0]}];
        case (r_row)
            2'd0: begin
                o_row.col0 = r_sn[0]; o_row.col1 = r_sn[1]; o_row.col2 = r_sn[2];
            end
            2'd1: begin
                o_row.col0 = r_uw[0]; o_row.col1 = r_uw[1]; o_row.col2 = r_uw[2];
            end
            2'd2: begin
                o_row.col0 = r_fw[0]; o_row.col1 = r_fw[1]; o_row.col2 = r_fw[2];
            end
            default: begin
                o_row.col0 = '0; o_row.col1 = '0; o_row.col2 = '0;
                o_row.col3 = 32'sd1 <<< FRAC_BITS;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        r_ptag <= r_cnt[3:0];
        if (o_job_take) begin
            r_pos <= i_job.pos;
            r_up  <= i_job.up;
            r_vec <= i_job.dir;
        end
        case (r_state)
            S_SQ: begin
                if (r_pv) begin
                    r_s <= a_sum;
                    if (r_ptag == 4'd2) begin
                        r_srem <= '0;
                        r_root <= '0;
                        if (a_sum == 64'd0) begin
                            if (r_pass) begin
                                r_sn <= '0;
                            end else begin
                                r_fw <= '0;
                            end
                        end
                    end
                end
            end
            S_SQRT: begin
                r_s    <= q_s[2];
                r_srem <= q_rem[2];
                r_root <= q_root[2];
                r_len  <= q_root[2];
                for (int i = 0; i < 3; i++) begin
                    r_rem[i]  <= v_num[i][NW-1:FRAC_BITS+1];
                    r_dnum[i] <= v_num[i][FRAC_BITS:0];
                end
            end
            S_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i]  <= d_rem[i][31:0];
                    r_dnum[i] <= {r_dnum[i][FRAC_BITS-1:0], 1'b0};
                    r_quo[i]  <= d_quo[i];
                end
                if (r_cnt == DIV_LAST) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_pass) begin
                            r_sn[i] <= d_res[i];
                        end else begin
                            r_fw[i] <= d_res[i];
                        end
                    end
                end
            end
            S_CROSS: begin
                if (r_pv) begin
                    if (!r_ptag[0]) begin
                        r_acc <= 66'(r_prod);
                    end else if (r_pass) begin
                        r_uw[r_ptag[2:1]] <= a_cross;
                    end else begin
                        r_vec[r_ptag[2:1]] <= a_cross;
                    end
                end
            end
            S_DOT: begin
                if (r_pv) begin
                    r_acc <= a_dsum;
                    if (h_k == 2'd2) begin
                        r_tr[h_row] <= a_tr;
                    end
                end
            end
            default: ;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_pass  <= 1'b0;
            r_degen <= 1'b0;
            r_row   <= '0;
        end else begin
            r_pv <= m_go;
            if (m_go) begin
                r_cnt <= r_cnt + 5'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_SQ;
                        r_cnt   <= '0;
                        r_pass  <= 1'b0;
                        r_degen <= 1'b0;
                    end
                end
                S_SQ: begin
                    if (r_pv && r_ptag == 4'd2) begin
                        r_cnt <= '0;
                        if (a_sum == 64'd0) begin
                            r_degen <= 1'b1;
                            r_state <= S_CROSS;
                        end else begin
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_cnt == 5'd15) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_CROSS;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_CROSS: begin
                    if (r_pv && r_ptag == 4'd5) begin
                        r_cnt <= '0;
                        if (r_pass) begin
                            r_state <= S_DOT;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_DOT: begin
                    if (r_pv && r_ptag == 4'd8) begin
                        r_cnt   <= '0;
                        r_row   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_row_full) begin
                        r_row <= r_row + 2'd1;
                        if (r_row == 2'd3) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/lav_outq.sv
// ----------------------------------------------------------------------------
// lav_outq
// Four-entry result queue; holds rows until the consumer pops them.
// ----------------------------------------------------------------------------
module lav_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  lav_pkg::t_out i_row,
    output logic          empty,
    input  logic          pop,
    output lav_pkg::t_out o_res
);
    import lav_pkg::*;

    t_out       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_pop;

    assign o_full = (r_cnt == 3'd4);
    assign empty  = (r_cnt == 3'd0);
    assign w_pop  = pop && !empty;
    assign o_res  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(w_pop);
        end
    end

endmodule

>>> design/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point look-at view matrix builder, four row results per request.
// ----------------------------------------------------------------------------
// Push a request of eye position, target and up vector (signed fixed point,
// FRAC_BITS fraction bits) while full is low; pop the four rows of the view
// matrix, row 0 first, while empty is low. Row 3 carries last_row. Each
// normalization runs the squares, the square root and the divide, then a
// cross product; the three translation dot products follow, then the rows
// are emitted, which stalls while the result queue is full. A zero-length
// vector skips its square root and divide. The pace is set by the shared
// multiplier, the square root unit that retires two result bits a cycle and
// the three divider lanes that retire one quotient bit a cycle. The front
// queue holds two requests and the result queue four rows, so pushing and
// popping proceed while the back end computes.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  lav_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output lav_pkg::t_out o_res
);
    import lav_pkg::*;

    logic job_valid, job_take;
    t_job job;
    logic row_push, row_full;
    t_out row;

    // front: accept requests and form pos - target
    lav_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_job_valid (job_valid),
        .i_job_take  (job_take),
        .o_job       (job)
    );

    // back: normalize, cross, dot, emit rows
    lav_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_take  (job_take),
        .i_job       (job),
        .o_row_push  (row_push),
        .i_row_full  (row_full),
        .o_row       (row)
    );

    // result queue
    lav_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (row_push),
        .o_full  (row_full),
        .i_row   (row),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    // last_row marks row 3 and only row 3
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_res.last_row == (o_res.row_index == 2'd3)))
        else $error("last_row does not match row index");

    // row 3 has col0 and col1 zero and col3 equal to one
    a_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.row_index == 2'd3) |->
        (o_res.col0 == 32'sd0 && o_res.col1 == 32'sd0 && o_res.col3 == ONE))
        else $error("row 3 is not 0 0 0 1");

    // the first component of the side and forward rows stays within unit magnitude
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_res.row_index == 2'd0 || o_res.row_index == 2'd2)) |->
        (o_res.col0 <= ONE && o_res.col0 >= -ONE))
        else $error("normalized component out of range");

    // rows of one request come out in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_res.last_row) |=>
        (!empty && o_res.row_index == $past(o_res.row_index) + 2'd1) || empty)
        else $error("row order broken");

endmodule
